// ===== rtl/core/mhin_pkg.sv =====
`timescale 1ns / 1ps
// Package for the magnetometer hard-iron normalize core: widths, item kinds,
// status codes and the lane control struct. No dependencies.
package mhin_pkg;

   localparam int SampleBits  = 16;
   localparam int OutFracBits = 14;
   localparam int RatioFrac   = 16;
   localparam int RatioBits   = 30;
   // |num| <= 2^(SampleBits+1), so num fits in this signed width and |num|<<16 in DivBits.
   localparam int NumBits     = SampleBits + 2;
   localparam int DivBits     = NumBits + RatioFrac;
   localparam int DenBits     = SampleBits + 1;
   localparam int SumBits     = 2 * RatioBits + 2;
   localparam int RootBits    = SumBits / 2;
   localparam int QuotBits    = RatioBits + OutFracBits;
   // The normalizing dividend carries half the root on top of the scaled
   // component, which can need one bit more than the quotient width.
   localparam int LaneBits    = QuotBits + 1;
   localparam int RootSteps   = SumBits / 2;
   localparam int CntBits     = 6;

   typedef enum logic [1:0] {
      KIND_CAL     = 2'd0,
      KIND_MEAS    = 2'd1,
      KIND_RESTART = 2'd2,
      KIND_UNUSED  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_UNCAL  = 2'd1,
      STATUS_ZERO   = 2'd2,
      STATUS_SPARE  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATIO,
      ST_SHIFT,
      ST_SQUARE,
      ST_ROOT,
      ST_NORM,
      ST_OUT
   } state_type;

   // Control from the sequencer to the three lanes.
   typedef struct packed {
      logic ratio_start;
      logic norm_start;
      logic step;
   } lane_ctrl_type;

endpackage

// ===== rtl/core/mhin_lane.sv =====
`timescale 1ns / 1ps
// One axis lane: bit-serial restoring divider used first for the ratio and
// then for the normalized component. Depends on mhin_pkg.
module mhin_lane
   import mhin_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  lane_ctrl_type                ctrl,
   input  logic signed [SampleBits-1:0] sample,
   input  logic signed [SampleBits-1:0] min_val,
   input  logic signed [SampleBits-1:0] max_val,
   input  logic [RatioBits-1:0]         mag,
   input  logic [RootBits-1:0]          root,
   output logic [DivBits-1:0]           ratio,
   output logic                         neg,
   output logic [QuotBits-1:0]          quot
);

   logic [LaneBits-1:0] dividend_ff, dividend_in;
   logic [RootBits:0]   rem_ff, rem_in;
   logic [RootBits-1:0] divisor_ff, divisor_in;
   logic                neg_ff, neg_in;
   logic signed [NumBits-1:0] num;
   logic [NumBits-1:0]  anum;
   logic [DenBits-1:0]  den;
   logic [RootBits:0]   shifted;
   logic [RootBits:0]   diff;

   assign num  = NumBits'(2 * NumBits'(sample)) - NumBits'(max_val) - NumBits'(min_val);
   assign anum = num[NumBits-1] ? NumBits'(-num) : NumBits'(num);
   assign den  = DenBits'(max_val) - DenBits'(min_val);

   assign shifted = {rem_ff[RootBits-1:0], dividend_ff[LaneBits-1]};
   assign diff    = shifted - {1'b0, divisor_ff};

   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      neg_in      = neg_ff;
      if (ctrl.ratio_start) begin
         dividend_in = LaneBits'({anum, {RatioFrac{1'b0}}});
         rem_in      = '0;
         divisor_in  = RootBits'(den);
         neg_in      = num[NumBits-1];
      end else if (ctrl.norm_start) begin
         // Component magnitude scaled, plus half the root for rounding.
         dividend_in = LaneBits'({mag, {OutFracBits{1'b0}}}) + LaneBits'(root >> 1);
         rem_in      = '0;
         divisor_in  = root;
      end else if (ctrl.step) begin
         if (!diff[RootBits]) begin
            rem_in = diff;
         end else begin
            rem_in = shifted;
         end
         dividend_in = {dividend_ff[LaneBits-2:0], ~diff[RootBits]};
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      if (reset) begin
         neg_ff <= 1'b0;
      end else begin
         neg_ff <= neg_in;
      end
   end

   assign ratio = DivBits'(dividend_ff);
   assign neg   = neg_ff;
   assign quot  = QuotBits'(dividend_ff);

endmodule

// ===== rtl/core/mhin_merge.sv =====
`timescale 1ns / 1ps
// Merging stage: common range shift, sum of squares and bit-serial integer
// square root. Depends on mhin_pkg.
module mhin_merge
   import mhin_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 shift_step,
   input  logic                 square,
   input  logic                 root_start,
   input  logic                 root_step,
   input  logic [DivBits-1:0]   mag_x,
   input  logic [DivBits-1:0]   mag_y,
   input  logic [DivBits-1:0]   mag_z,
   output logic [RatioBits-1:0] sm_x,
   output logic [RatioBits-1:0] sm_y,
   output logic [RatioBits-1:0] sm_z,
   output logic                 shift_done,
   output logic [RootBits-1:0]  root
);

   logic [DivBits-1:0] mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;
   logic [SumBits-1:0] sum_ff, sum_in;
   logic [SumBits-1:0] res_ff, res_in;
   logic [SumBits-1:0] bit_ff, bit_in;
   logic [DivBits-1:0] top;

   assign top        = mx_ff | my_ff | mz_ff;
   assign shift_done = (top >> RatioBits) == '0;

   always_comb begin
      mx_in = mx_ff; my_in = my_ff; mz_in = mz_ff;
      sum_in = sum_ff; res_in = res_ff; bit_in = bit_ff;
      if (load) begin
         mx_in = mag_x; my_in = mag_y; mz_in = mag_z;
      end else if (shift_step) begin
         mx_in = mx_ff >> 1; my_in = my_ff >> 1; mz_in = mz_ff >> 1;
      end
      if (square) begin
         sum_in = SumBits'(sm_x * sm_x) + SumBits'(sm_y * sm_y)
                + SumBits'(sm_z * sm_z);
      end
      if (root_start) begin
         res_in = '0;
         bit_in = SumBits'(1) << (SumBits - 2);
      end else if (root_step) begin
         if (sum_ff >= res_ff + bit_ff) begin
            sum_in = sum_ff - (res_ff + bit_ff);
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      mx_ff <= mx_in; my_ff <= my_in; mz_ff <= mz_in;
      sum_ff <= sum_in; res_ff <= res_in;
      if (reset) begin
         bit_ff <= '0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   assign sm_x = RatioBits'(mx_ff);
   assign sm_y = RatioBits'(my_ff);
   assign sm_z = RatioBits'(mz_ff);
   assign root = RootBits'(res_ff);

endmodule

// ===== rtl/core/magnetometer_hard_iron_normalize_core.sv =====
`timescale 1ns / 1ps
// Top level of the magnetometer hard-iron normalize core: calibration store,
// sequencer, three axis lanes and the merging stage. Depends on mhin_pkg.
//
// Usage: each req_ word carries a kind and a three-axis sample. A restart word
// resets the per-axis minima and maxima, a calibration word widens them, and
// both finish with no result. A measurement word gives one rsp_ word: the
// hard-iron corrected, unit length vector in Q2.14 with Y and Z negated, and
// a status (ok, uncalibrated axis, zero magnitude). Kind 3 is dropped. One
// word is worked at a time; req_ready is low while a measurement is in
// flight. A measurement runs the ratio divide in the three lanes, the range
// shifts, the squares, the square root and the normalizing divide, then
// loads the output. A zero magnitude skips the normalizing divide, an
// uncalibrated axis skips everything. The bit-serial dividers and square
// root set the rate: with a ready receiver a new measurement can be accepted
// in the cycle in which rsp_valid rises. A stalled receiver holds the result
// in the output register and blocks req_ready. Reset (synchronous) sets all
// minima to 32767 and maxima to -32768 and empties the output register.
module magnetometer_hard_iron_normalize_core
   import mhin_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_kind,
   input  logic signed [SampleBits-1:0] req_sample_x,
   input  logic signed [SampleBits-1:0] req_sample_y,
   input  logic signed [SampleBits-1:0] req_sample_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [15:0]           rsp_unit_x,
   output logic signed [15:0]           rsp_unit_y,
   output logic signed [15:0]           rsp_unit_z,
   output logic [1:0]                   rsp_status
);

   state_type state_ff, state_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic signed [SampleBits-1:0] min_ff [3];
   logic signed [SampleBits-1:0] max_ff [3];
   logic signed [SampleBits-1:0] smp_ff [3];
   logic signed [SampleBits-1:0] smp_in [3];
   logic rsp_valid_ff;
   logic signed [15:0] ux_ff, uy_ff, uz_ff;
   logic [1:0] status_ff;
   logic accept, uncal;
   lane_ctrl_type ctrl;
   logic load, shift_step, square, root_start, root_step, shift_done, capture;
   logic capture_uncal, capture_zero;
   logic [DivBits-1:0] ratio [3];
   logic neg [3];
   logic [QuotBits-1:0] quot [3];
   logic [RatioBits-1:0] sm [3];
   logic [RootBits-1:0] root;
   logic signed [15:0] unit [3];

   assign accept = req_valid && req_ready;
   assign smp_in[0] = req_sample_x;
   assign smp_in[1] = req_sample_y;
   assign smp_in[2] = req_sample_z;
   assign uncal = (max_ff[0] <= min_ff[0]) || (max_ff[1] <= min_ff[1])
                || (max_ff[2] <= min_ff[2]);

   // Next state.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_MEAS) begin
               state_in = ST_RATIO;
               cnt_in   = '0;
            end
         end
         ST_RATIO: begin
            if (uncal) begin
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CntBits'(LaneBits + 1)) begin
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (shift_done) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_ROOT;
            cnt_in   = '0;
         end
         ST_ROOT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntBits'(RootSteps + 1)) begin
               state_in = (root == '0) ? ST_OUT : ST_NORM;
               cnt_in   = '0;
            end
         end
         ST_NORM: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntBits'(LaneBits)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      ctrl          = '0;
      load          = 1'b0;
      shift_step    = 1'b0;
      square        = 1'b0;
      root_start    = 1'b0;
      root_step     = 1'b0;
      capture       = 1'b0;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = !rsp_valid_ff || rsp_ready;
         ST_RATIO: begin
            ctrl.ratio_start = (cnt_ff == '0);
            ctrl.step        = (cnt_ff != '0) && (cnt_ff <= CntBits'(LaneBits));
            load             = (cnt_ff == CntBits'(LaneBits + 1));
         end
         ST_SHIFT:  shift_step = !shift_done;
         ST_SQUARE: square = 1'b1;
         ST_ROOT: begin
            root_start = (cnt_ff == '0);
            root_step  = (cnt_ff != '0) && (cnt_ff <= CntBits'(RootSteps));
         end
         ST_NORM: begin
            ctrl.norm_start = (cnt_ff == '0);
            ctrl.step       = (cnt_ff != '0);
         end
         ST_OUT:    capture = !rsp_valid_ff || rsp_ready;
         default:   req_ready = 1'b0;
      endcase
   end

   assign capture_uncal = uncal;
   assign capture_zero  = (root == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            min_ff[i] <= SampleBits'((1 << (SampleBits - 1)) - 1);
            max_ff[i] <= SampleBits'(1 << (SampleBits - 1));
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         for (int i = 0; i < 3; i++) begin
            if (accept && req_kind == KIND_RESTART) begin
               min_ff[i] <= SampleBits'((1 << (SampleBits - 1)) - 1);
               max_ff[i] <= SampleBits'(1 << (SampleBits - 1));
            end else if (accept && req_kind == KIND_CAL) begin
               if (smp_in[i] < min_ff[i]) begin
                  min_ff[i] <= smp_in[i];
               end
               if (smp_in[i] > max_ff[i]) begin
                  max_ff[i] <= smp_in[i];
               end
            end
         end
         if (capture) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         smp_ff <= smp_in;
      end
      if (capture) begin
         if (capture_uncal) begin
            ux_ff <= '0; uy_ff <= '0; uz_ff <= '0;
            status_ff <= STATUS_UNCAL;
         end else if (capture_zero) begin
            ux_ff <= '0; uy_ff <= '0; uz_ff <= '0;
            status_ff <= STATUS_ZERO;
         end else begin
            ux_ff <= unit[0]; uy_ff <= unit[1]; uz_ff <= unit[2];
            status_ff <= STATUS_OK;
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      logic flip;
      mhin_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .sample  (smp_ff[g]),
         .min_val (min_ff[g]),
         .max_val (max_ff[g]),
         .mag     (sm[g]),
         .root    (root),
         .ratio   (ratio[g]),
         .neg     (neg[g]),
         .quot    (quot[g])
      );
      // Y and Z leave with the opposite sign, so the saturation follows the
      // final sign of each component.
      assign flip = (g == 0) ? neg[g] : !neg[g];
      always_comb begin
         if (flip) begin
            if (quot[g] >= QuotBits'(32768)) begin
               unit[g] = -16'sd32767 - 16'sd1;
            end else begin
               unit[g] = -16'(quot[g]);
            end
         end else begin
            if (quot[g] > QuotBits'(32767)) begin
               unit[g] = 16'sd32767;
            end else begin
               unit[g] = 16'(quot[g]);
            end
         end
      end
   end

   mhin_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .shift_step (shift_step),
      .square     (square),
      .root_start (root_start),
      .root_step  (root_step),
      .mag_x      (ratio[0]),
      .mag_y      (ratio[1]),
      .mag_z      (ratio[2]),
      .sm_x       (sm[0]),
      .sm_y       (sm[1]),
      .sm_z       (sm[2]),
      .shift_done (shift_done),
      .root       (root)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_unit_x = ux_ff;
   assign rsp_unit_y = uy_ff;
   assign rsp_unit_z = uz_ff;
   assign rsp_status = status_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for magnetometer_hard_iron_normalize_core: drives calibration,
// measurement and restart words and checks each result against an internal
// predictor of the min/max hard-iron correction. Depends on mhin_pkg.
module tb_top
   import mhin_pkg::*;
();

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_kind = 2'd0;
   logic signed [15:0] req_sample_x = '0, req_sample_y = '0, req_sample_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_unit_x, rsp_unit_y, rsp_unit_z;
   logic [1:0] rsp_status;

   typedef struct packed {
      logic signed [15:0] ux;
      logic signed [15:0] uy;
      logic signed [15:0] uz;
      logic [1:0]         st;
   } unit_vec_type;

   unit_vec_type expected_vecs[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Predictor copy of the calibration store.
   logic signed [15:0] cal_min[3];
   logic signed [15:0] cal_max[3];

   magnetometer_hard_iron_normalize_core uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   // Applies one word to the predictor; returns 1 when a result is due.
   function automatic bit predict_vector(logic [1:0] kind, logic signed [15:0] sx,
                                         logic signed [15:0] sy, logic signed [15:0] sz,
                                         output unit_vec_type vec);
      longint s[3];
      longint mag[3];
      bit neg[3];
      longint u[3];
      longint num, den, top, q;
      logic [63:0] sum, m;
      int sh;
      s[0] = sx; s[1] = sy; s[2] = sz;
      vec = '0;
      if (kind == KIND_RESTART) begin
         for (int i = 0; i < 3; i++) begin
            cal_min[i] = 16'sd32767;
            cal_max[i] = -16'sd32768;
         end
         return 0;
      end
      if (kind == KIND_CAL) begin
         for (int i = 0; i < 3; i++) begin
            if (s[i] < cal_min[i]) cal_min[i] = s[i];
            if (s[i] > cal_max[i]) cal_max[i] = s[i];
         end
         return 0;
      end
      if (kind != KIND_MEAS) return 0;
      for (int i = 0; i < 3; i++) begin
         if (cal_max[i] <= cal_min[i]) begin
            vec.st = STATUS_UNCAL;
            return 1;
         end
      end
      top = 0;
      for (int i = 0; i < 3; i++) begin
         num = 2 * s[i] - longint'(cal_max[i]) - longint'(cal_min[i]);
         den = longint'(cal_max[i]) - longint'(cal_min[i]);
         neg[i] = num < 0;
         if (neg[i]) num = -num;
         mag[i] = (num <<< 16) / den;
         if (mag[i] > top) top = mag[i];
      end
      sh = 0;
      while ((top >>> sh) >= (64'd1 << 30)) sh++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = mag[i] >>> sh;
         sum += mag[i] * mag[i];
      end
      m = root_floor(sum);
      if (m == 0) begin
         vec.st = STATUS_ZERO;
         return 1;
      end
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] <<< OutFracBits) + longint'(m >> 1)) / longint'(m);
         u[i] = neg[i] ? -q : q;
      end
      vec.ux = clamp16(u[0]);
      vec.uy = clamp16(-u[1]);
      vec.uz = clamp16(-u[2]);
      vec.st = STATUS_OK;
      return 1;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("error: %s got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // Called at a rising edge; valid stays high from the last accept unless
   // the sender idles first, so valid is written once per time step.
   task automatic send_word(logic [1:0] kind, logic signed [15:0] sx,
                            logic signed [15:0] sy, logic signed [15:0] sz);
      unit_vec_type vec;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_sample_x <= sx;
      req_sample_y <= sy;
      req_sample_z <= sz;
      do @(posedge clock); while (!req_ready);
      if (predict_vector(kind, sx, sy, sz, vec)) expected_vecs.push_back(vec);
   endtask

   // Receiver: random back-pressure and field checks.
   always @(posedge clock) begin
      unit_vec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_vecs.size() == 0) begin
            report_mismatch("unexpected word, status", rsp_status, -1);
         end else begin
            want = expected_vecs.pop_front();
            if (rsp_unit_x !== want.ux) report_mismatch("unit_x", rsp_unit_x, want.ux);
            if (rsp_unit_y !== want.uy) report_mismatch("unit_y", rsp_unit_y, want.uy);
            if (rsp_unit_z !== want.uz) report_mismatch("unit_z", rsp_unit_z, want.uz);
            if (rsp_status !== want.st) report_mismatch("status", rsp_status, want.st);
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic signed [15:0] rand_sample();
      return 16'($urandom());
   endfunction

   task automatic test_directed();
      send_word(KIND_MEAS, 0, 0, 0);
      send_word(KIND_CAL, 100, -100, 5);
      send_word(KIND_MEAS, 1, 2, 3);
      send_word(KIND_CAL, 200, 100, 50);
      send_word(KIND_MEAS, 150, 0, 27);
      send_word(KIND_MEAS, 32767, 32767, 32767);
      send_word(KIND_MEAS, -32768, -32768, -32768);
      send_word(KIND_MEAS, -32768, 32767, 0);
      send_word(KIND_UNUSED, 1, 1, 1);
      send_word(KIND_MEAS, 150, 1, 28);
      send_word(KIND_RESTART, 0, 0, 0);
      send_word(KIND_MEAS, 150, 1, 28);
      send_word(KIND_CAL, -32768, -32768, -32768);
      send_word(KIND_CAL, 32767, 32767, 32767);
      send_word(KIND_MEAS, -32768, 32767, -1);
      send_word(KIND_MEAS, 0, -1, 16'h5555);
      send_word(KIND_RESTART, 0, 0, 0);
      send_word(KIND_CAL, 0, 0, 0);
      send_word(KIND_CAL, 1, 1, 1);
      send_word(KIND_MEAS, 32767, -32768, 16'hAAAA);
   endtask

   task automatic test_random(int count);
      logic signed [15:0] c[3];
      logic [15:0] span;
      int n;
      while (count > 0) begin
         n = $urandom_range(99);
         if (n < 8) begin
            send_word(KIND_RESTART, rand_sample(), rand_sample(), rand_sample());
            count--;
         end else if (n < 12) begin
            send_word(KIND_UNUSED, rand_sample(), rand_sample(), rand_sample());
         end else if (n < 50) begin
            // Calibration around a random center with a random span.
            span = 16'd1 << $urandom_range(15);
            for (int i = 0; i < 3; i++)
               c[i] = rand_sample() + $signed(16'($urandom_range(span)));
            send_word(KIND_CAL, c[0], c[1], c[2]);
            count--;
         end else if (n < 85) begin
            for (int i = 0; i < 3; i++)
               c[i] = (cal_min[i] >>> 1) + (cal_max[i] >>> 1)
                      + $signed(16'($urandom_range(32)) - 16'sd16);
            send_word(KIND_MEAS, c[0], c[1], c[2]);
            count--;
         end else begin
            send_word(KIND_MEAS, rand_sample(), rand_sample(), rand_sample());
            count--;
         end
      end
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (expected_vecs.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (150) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < 3; i++) begin
         cal_min[i] = 16'sd32767;
         cal_max[i] = -16'sd32768;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 25; recv_idle_pct = 67;
      test_directed();
      test_random(300);
      send_idle_pct = 67; recv_idle_pct = 25;
      test_random(300);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(330);
      drain();
      if (errors == 0 && expected_vecs.size() == 0) begin
         $display("magnetometer_hard_iron_normalize_core: match");
      end else begin
         $display("magnetometer_hard_iron_normalize_core: mismatch");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("magnetometer_hard_iron_normalize_core: mismatch");
      $finish;
   end
endmodule

// ===== magnetometer_hard_iron_normalize_core.f =====
rtl/core/mhin_pkg.sv
rtl/core/mhin_lane.sv
rtl/core/mhin_merge.sv
rtl/core/magnetometer_hard_iron_normalize_core.sv
tb/sv/tb_top.sv
